@@ hw/rtl/tmtw_pkg.sv @@
// ============================================================================
// tmtw_pkg
// Shared widths, command codes and cell constants of the text terminal writer.
// ============================================================================
package tmtw_pkg;

    localparam int MODE_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ATTR_W-1:0] attr_t;

    localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_END   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    localparam logic REG_TEXT_COLOR = 1'b0;

    localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;
    localparam attr_t             SCROLL_ATTR = 8'h07;
    localparam attr_t             RESET_COLOR = 8'h07;

endpackage

@@ hw/rtl/text_mode_terminal_writer.sv @@
// ============================================================================
// text_mode_terminal_writer
// Character cell store with cursor: put, line control, clear, scroll, read.
// ============================================================================
// Put char, start line, end line, clear, out-of-range reads and unused modes
// give their result in the cycle after acceptance; an in-range cell read
// passes through the memory read register and the S_READ state first.
// Throughput: one transaction per cycle for cursor-only and put commands
// while the output is not stalled. Clear and scroll keep input stalled while
// the single write port of the cell memory walks every cell.
// After reset a clearing pass over every cell runs before the first
// transaction is accepted; configuration writes are taken throughout.
module text_mode_terminal_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tmtw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tmtw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tmtw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tmtw_pkg::MODE_W-1:0]        mode,
    input  logic [tmtw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tmtw_pkg::ROW_W-1:0]         read_row,
    input  logic [tmtw_pkg::COL_W-1:0]         read_col,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tmtw_pkg::CELL_W-1:0]        cell_value,
    output logic [tmtw_pkg::ROW_W-1:0]         cursor_row,
    output logic [tmtw_pkg::COL_W-1:0]         cursor_col
);
    import tmtw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int LINW   = ROW_W + CW + 2;
    localparam int LIMIT  = (ROWS - 1) * COLUMNS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_FILL   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    attr_t             fill_attr_reg, fill_attr_next;
    logic              mv_valid_reg, mv_valid_next;
    logic [ADDR_W-1:0] mv_addr_reg, mv_addr_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    attr_t             color_reg;
    logic              out_valid_reg, out_valid_next;
    cell_t             cell_reg, cell_next;
    cell_t             rdata_reg;

    cell_t             mem [CELLS];

    logic              accept;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    cell_t             mem_wd;
    logic [ADDR_W-1:0] mem_ra;
    logic [ADDR_W-1:0] cur_addr;
    logic [LINW-1:0]   rd_lin;
    logic              rd_in_range;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TEXT_COLOR) ? APB_DATA_W'(color_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= RESET_COLOR;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_COLOR)
        begin
            color_reg <= pwdata[ATTR_W-1:0];
        end
    end

    // handshake and addressing
    assign in_ready    = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign cell_value  = cell_reg;
    assign cursor_row  = ROW_W'(row_reg);
    assign cursor_col  = COL_W'(col_reg);

    assign cur_addr    = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign rd_lin      = LINW'(read_row) * LINW'(COLUMNS) + LINW'(read_col);
    assign rd_in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cur_addr;
        mem_wd = {color_reg, char_code};
        if (mv_valid_reg)
        begin
            mem_we = 1'b1;
            mem_wa = mv_addr_reg;
            mem_wd = rdata_reg;
        end
        else if (state_reg == S_FILL)
        begin
            mem_we = 1'b1;
            mem_wa = idx_reg;
            mem_wd = {fill_attr_reg, BLANK_CHAR};
        end
        else if (accept && mode == MODE_PUT)
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_ra = (state_reg == S_SCROLL) ? ADDR_W'(idx_reg + ADDR_W'(COLUMNS))
                                            : rd_lin[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fill_attr_next = fill_attr_reg;
        mv_valid_next  = 1'b0;
        mv_addr_next   = mv_addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cell_next      = cell_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    cell_next      = '0;
                    case (mode)
                        MODE_PUT:
                        begin
                            if (col_reg == CW'(COLUMNS - 1))
                            begin
                                col_next = '0;
                                row_next = (row_reg == RW'(ROWS - 1)) ? '0 : row_reg + 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        MODE_START:
                        begin
                            col_next = '0;
                        end
                        MODE_END:
                        begin
                            if (row_reg == RW'(ROWS - 1))
                            begin
                                state_next = S_SCROLL;
                                idx_next   = '0;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            row_next       = '0;
                            col_next       = '0;
                            state_next     = S_FILL;
                            idx_next       = '0;
                            fill_attr_next = color_reg;
                        end
                        MODE_READ:
                        begin
                            if (rd_in_range)
                            begin
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            cell_next = '0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                cell_next      = rdata_reg;
                state_next     = S_IDLE;
            end
            S_SCROLL:
            begin
                // read runs one cell ahead of the write-back; last step drains it
                if (idx_reg == ADDR_W'(LIMIT))
                begin
                    state_next     = S_FILL;
                    fill_attr_next = SCROLL_ATTR;
                end
                else
                begin
                    mv_valid_next = 1'b1;
                    mv_addr_next  = idx_reg;
                    idx_next      = idx_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                if (idx_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            idx_reg       <= '0;
            fill_attr_reg <= RESET_COLOR;
            mv_valid_reg  <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fill_attr_reg <= fill_attr_next;
            mv_valid_reg  <= mv_valid_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_addr_reg <= mv_addr_next;
        cell_reg    <= cell_next;
    end

    // checks
    a_fill_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> !mv_valid_reg)
        else $error("move write overlaps fill write");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL) |-> (row_reg == RW'(ROWS - 1)))
        else $error("scroll while cursor not on last row");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> out_valid_reg)
        else $error("cell read produced no result");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS)))
        else $error("cursor out of range");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE) && !mv_valid_reg)
        else $error("input taken while memory walk is active");

endmodule
